FILE: hw/rtl/dmfc_pkg.sv
// Package for the double / 44-bit float word converter.
// Holds command codes, field constants and leading-zero count helpers.
// No dependencies.
package dmfc_pkg;

  // Conversion direction carried on tuser.
  typedef enum logic {
    CMD_TO_WORD   = 1'b0,
    CMD_TO_DOUBLE = 1'b1
  } dmfc_cmd_t;

  localparam int WORD_FRAC_W = 36;
  localparam int WORD_EXP_W  = 7;
  localparam logic [WORD_FRAC_W-1:0] FRAC_ONES = '1;
  localparam logic [10:0] DBL_EXP_SPECIAL = 11'h7FF;

  // Leading zeros of a 52-bit value; the value must be nonzero.
  function automatic logic [5:0] lzc52(input logic [51:0] v);
    logic [5:0] n;
    n = 6'd0;
    for (int i = 0; i < 52; i++) begin
      if (v[i]) n = 6'(51 - i);
    end
    return n;
  endfunction

  // Leading zeros of a 36-bit value; the value must be nonzero.
  function automatic logic [5:0] lzc36(input logic [35:0] v);
    logic [5:0] n;
    n = 6'd0;
    for (int i = 0; i < 36; i++) begin
      if (v[i]) n = 6'(35 - i);
    end
    return n;
  endfunction

endpackage

FILE: hw/rtl/double_m20_float_converter.sv
// Top level of the double / 44-bit float word converter.
// Depends on dmfc_pkg for command codes and leading-zero counters.
//
// Converts IEEE 754 double bit patterns to a 44-bit float word (sign bit 43,
// exponent biased by 64 in bits 42..36, 36-bit fraction) when in_tuser is 0,
// and such a word (in in_tdata[43:0]) back to a double when in_tuser is 1.
// One item is accepted per cycle while out_tready does not stall the pipeline. An
// item sits in the input register after the edge that accepts it, and its result
// is then loaded into the output register, which raises out_tvalid. Backpressure
// on out_tready stalls both registers.
module double_m20_float_converter (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // [63:0] operand
  input  logic [0:0]  in_tuser,   // [0] command
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata   // [63:0] result
);
  import dmfc_pkg::*;

  logic        s1_valid_r, s1_valid_nxt;
  logic        s1_cmd_r;
  logic [63:0] s1_op_r;
  logic        s2_valid_r, s2_valid_nxt;
  logic        s2_cmd_r;
  logic [63:0] s2_res_r;
  logic        s2_ready, s1_ready;

  // Pipeline handshake: each stage loads when it is empty or the one after it moves.
  assign s2_ready  = !s2_valid_r || out_tready;
  assign s1_ready  = !s1_valid_r || s2_ready;
  assign in_tready = s1_ready;

  always_comb begin
    s1_valid_nxt = s1_ready ? in_tvalid : s1_valid_r;
    s2_valid_nxt = s2_ready ? s1_valid_r : s2_valid_r;
  end

  // Double to word conversion.
  logic              d_sgn;
  logic [10:0]       d_exp;
  logic [51:0]       d_frac;
  logic [5:0]        d_lz;
  logic [52:0]       d_m;
  logic signed [11:0] d_ex;
  logic [36:0]       d_rnd;
  logic [35:0]       d_wfrac;
  logic [63:0]       word_res;

  always_comb begin
    d_sgn  = s1_op_r[63];
    d_exp  = s1_op_r[62:52];
    d_frac = s1_op_r[51:0];
    d_lz   = lzc52(d_frac);
    if (d_exp == 11'd0) begin
      d_m  = 53'({1'b0, d_frac} << (d_lz + 6'd1));
      d_ex = -12'sd1022 - $signed({6'd0, d_lz});
    end else begin
      d_m  = {1'b1, d_frac};
      d_ex = $signed({1'b0, d_exp}) - 12'sd1022;
    end
    // Round half up, then renormalize on a carry out.
    d_rnd = {1'b0, d_m[52:17]} + 37'(d_m[16]);
    if (d_rnd[36]) begin
      d_wfrac = {1'b1, 35'd0};
      d_ex    = d_ex + 12'sd1;
    end else begin
      d_wfrac = d_rnd[35:0];
    end
    if (d_ex < -12'sd64) begin
      d_ex = -12'sd64;
    end
    if (d_ex > 12'sd63) begin
      d_ex    = 12'sd63;
      d_wfrac = FRAC_ONES;
    end
    word_res = {20'd0, d_sgn, 7'(d_ex + 12'sd64), d_wfrac};
    // Special operands.
    if (d_exp == DBL_EXP_SPECIAL) begin
      word_res = {20'd0, d_sgn && (d_frac == 52'd0), 7'h7F, FRAC_ONES};
    end else if (d_exp == 11'd0 && d_frac == 52'd0) begin
      word_res = {20'd0, 1'b0, 7'd64, 36'd0};
    end
  end

  // Word to double conversion.
  logic        w_sgn;
  logic [6:0]  w_exp;
  logic [35:0] w_frac;
  logic [5:0]  w_lz;
  logic [35:0] w_norm;
  logic [10:0] w_be;
  logic [63:0] dbl_res;

  always_comb begin
    w_sgn  = s1_op_r[43];
    w_exp  = s1_op_r[42:36];
    w_frac = s1_op_r[35:0];
    w_lz   = lzc36(w_frac);
    w_norm = w_frac << w_lz;
    w_be   = 11'd958 + {4'd0, w_exp} - {5'd0, w_lz};
    if (w_frac == 36'd0) begin
      dbl_res = {w_sgn, 63'd0};
    end else begin
      dbl_res = {w_sgn, w_be, w_norm[34:0], 17'd0};
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
      s2_valid_r <= s2_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (s1_ready && in_tvalid) begin
      s1_op_r  <= in_tdata;
      s1_cmd_r <= in_tuser[0];
    end
    if (s2_ready && s1_valid_r) begin
      s2_cmd_r <= s1_cmd_r;
      s2_res_r <= (s1_cmd_r == CMD_TO_DOUBLE) ? dbl_res : word_res;
    end
  end

  assign out_tvalid = s2_valid_r;
  assign out_tdata  = s2_res_r;

  // A word result never sets bits above the word.
  a_word_upper_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (s2_cmd_r == CMD_TO_WORD) |-> out_tdata[63:44] == 20'd0)
    else $error("word result has upper bits set");

  // With no backpressure at the output, the input is always open.
  a_ready_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
    out_tready |-> in_tready)
    else $error("input stalled while output drains");

  // A held input stage moves to the output when the output is free.
  a_stage_advance: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && s2_ready |=> out_tvalid)
    else $error("item lost between stages");

endmodule
